// File: rtl/cmf_pkg.sv
// Shared types and constants for the chunked message framer.
// Used by cmf_front, cmf_queue, cmf_back and chunked_message_framer_unit.
package cmf_pkg;

   localparam int MAX_NOTIFY_BYTES = 244;
   localparam int HDR_BYTES        = 8;
   localparam int SMALL_MTU_VALUE  = 20;
   localparam int MTU_OVERHEAD     = 3;
   localparam int FRAME_VERSION    = 1;

   localparam int CHUNK_W  = $clog2(MAX_NOTIFY_BYTES + 1);
   localparam int BEAT_W   = $clog2(HDR_BYTES + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATT_MTU    = 1'b0,
      CSR_LINK_READY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [7:0]  msg_type;
      logic [15:0] message_id;
      logic [15:0] byte_offset;
      logic [15:0] msg_length;
      logic        with_header;
      logic        chunk_end;
   } cmf_entry_type;

endpackage

// File: rtl/cmf_front.sv
// Front end: configuration registers, message/chunk tracking, item classification.
// Depends on cmf_pkg.
module cmf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cmf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cmf_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        data_byte,
   input  logic [7:0]                        msg_type,
   input  logic [15:0]                       msg_length,
   input  logic                              queue_full,
   output logic                              queue_push,
   output cmf_pkg::cmf_entry_type            queue_entry
);

   logic [15:0]                 att_mtu_ff;
   logic                        link_ready_ff;
   logic [15:0]                 message_id_ff, message_id_in;
   logic [15:0]                 byte_offset_ff;
   logic [cmf_pkg::CHUNK_W-1:0] chunk_fill_ff, fill_base, fill_inc;
   logic [cmf_pkg::CHUNK_W-1:0] payload_ff, payload_in, payload_new;
   logic                        sending_ff;
   logic                        accept, new_msg, open_msg, send, msg_end, chunk_last;
   logic [15:0]                 cap;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (att_mtu_ff > 16'(cmf_pkg::MTU_OVERHEAD)) begin
         cap = att_mtu_ff - 16'(cmf_pkg::MTU_OVERHEAD);
      end else begin
         cap = 16'(cmf_pkg::SMALL_MTU_VALUE);
      end
      if (cap > 16'(cmf_pkg::MAX_NOTIFY_BYTES)) begin
         cap = 16'(cmf_pkg::MAX_NOTIFY_BYTES);
      end
      if (cap < 16'(cmf_pkg::HDR_BYTES + 1)) begin
         cap = 16'(cmf_pkg::HDR_BYTES + 1);
      end
      payload_new = cmf_pkg::CHUNK_W'(cap - 16'(cmf_pkg::HDR_BYTES));
   end

   assign new_msg       = (byte_offset_ff == 16'd0);
   assign open_msg      = new_msg && link_ready_ff;
   assign fill_base     = new_msg ? '0 : chunk_fill_ff;
   assign send          = (new_msg ? link_ready_ff : sending_ff) && link_ready_ff;
   assign message_id_in = open_msg ? message_id_ff + 16'd1 : message_id_ff;
   assign payload_in    = open_msg ? payload_new : payload_ff;
   assign msg_end       = ({1'b0, byte_offset_ff} + 17'd1) >= {1'b0, msg_length};
   assign fill_inc      = fill_base + cmf_pkg::CHUNK_W'(1);
   assign chunk_last    = msg_end || (fill_inc >= payload_in);

   assign queue_push              = accept && send;
   assign queue_entry.data_byte   = data_byte;
   assign queue_entry.msg_type    = msg_type;
   assign queue_entry.message_id  = message_id_in;
   assign queue_entry.byte_offset = byte_offset_ff;
   assign queue_entry.msg_length  = msg_length;
   assign queue_entry.with_header = (fill_base == '0);
   assign queue_entry.chunk_end   = chunk_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         att_mtu_ff     <= 16'd23;
         link_ready_ff  <= 1'b0;
         message_id_ff  <= '0;
         byte_offset_ff <= '0;
         chunk_fill_ff  <= '0;
         payload_ff     <= '0;
         sending_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               cmf_pkg::CSR_ATT_MTU:    att_mtu_ff    <= csr_data;
               cmf_pkg::CSR_LINK_READY: link_ready_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (accept) begin
            message_id_ff <= message_id_in;
            payload_ff    <= payload_in;
            if (msg_end) begin
               byte_offset_ff <= '0;
               chunk_fill_ff  <= '0;
               sending_ff     <= 1'b0;
            end else begin
               byte_offset_ff <= byte_offset_ff + 16'd1;
               sending_ff     <= send;
               if (send) begin
                  chunk_fill_ff <= chunk_last ? '0 : fill_inc;
               end else begin
                  chunk_fill_ff <= fill_base;
               end
            end
         end
      end
   end

endmodule

// File: rtl/cmf_queue.sv
// Short show-ahead queue between the front and back ends.
// Depends on cmf_pkg.
module cmf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cmf_pkg::cmf_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output cmf_pkg::cmf_entry_type head_entry
);

   cmf_pkg::cmf_entry_type          slots_ff [cmf_pkg::QUEUE_DEPTH];
   logic [cmf_pkg::QUEUE_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [cmf_pkg::QUEUE_CW-1:0]    count_ff;

   assign full       = (count_ff == cmf_pkg::QUEUE_CW'(cmf_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + cmf_pkg::QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + cmf_pkg::QUEUE_AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + cmf_pkg::QUEUE_CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - cmf_pkg::QUEUE_CW'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cmf_pkg::QUEUE_CW'(cmf_pkg::QUEUE_DEPTH))
      else $error("queue count over depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

// File: rtl/cmf_back.sv
// Back end: expands queued entries into header and payload bytes on the result stream.
// Depends on cmf_pkg.
module cmf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  cmf_pkg::cmf_entry_type head_entry,
   output logic                   queue_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             out_byte,
   output logic                   chunk_end,
   output logic                   run_last
);

   logic                        mid_ff;
   logic [cmf_pkg::BEAT_W-1:0]  beat_ff, beat;
   logic                        rsp_valid_ff;
   logic [7:0]                  byte_ff, byte_in;
   logic                        chunk_end_ff, run_last_ff;
   logic                        emit, last_beat;
   logic [7:0]                  hdr_bytes [cmf_pkg::HDR_BYTES];

   always_comb begin
      hdr_bytes[0] = 8'(cmf_pkg::FRAME_VERSION);
      hdr_bytes[1] = head_entry.msg_type;
      hdr_bytes[2] = head_entry.message_id[7:0];
      hdr_bytes[3] = head_entry.message_id[15:8];
      hdr_bytes[4] = head_entry.byte_offset[7:0];
      hdr_bytes[5] = head_entry.byte_offset[15:8];
      hdr_bytes[6] = head_entry.msg_length[7:0];
      hdr_bytes[7] = head_entry.msg_length[15:8];
   end

   assign beat      = mid_ff ? beat_ff
                    : (head_entry.with_header ? '0 : cmf_pkg::BEAT_W'(cmf_pkg::HDR_BYTES));
   assign last_beat = (beat == cmf_pkg::BEAT_W'(cmf_pkg::HDR_BYTES));
   assign emit      = !queue_empty && (!rsp_valid_ff || rsp_tready);
   assign queue_pop = emit && last_beat;
   assign byte_in   = last_beat ? head_entry.data_byte
                    : hdr_bytes[beat[$clog2(cmf_pkg::HDR_BYTES)-1:0]];

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff      <= byte_in;
         chunk_end_ff <= last_beat && head_entry.chunk_end;
         run_last_ff  <= last_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff       <= 1'b0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit || (rsp_valid_ff && !rsp_tready);
         if (emit) begin
            mid_ff  <= !last_beat;
            beat_ff <= beat + cmf_pkg::BEAT_W'(1);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_byte   = byte_ff;
   assign chunk_end  = chunk_end_ff;
   assign run_last   = run_last_ff;

`ifndef SYNTHESIS
   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> (beat_ff != '0) && (beat_ff <= cmf_pkg::BEAT_W'(cmf_pkg::HDR_BYTES)))
      else $error("beat counter out of range inside an entry");
   a_pop_on_run_end: assert property (@(posedge clock) disable iff (reset)
      queue_pop |=> rsp_tvalid && run_last)
      else $error("entry retired without its payload byte");
`endif

endmodule

// File: rtl/chunked_message_framer_unit.sv
// Top level of the chunked message framer: front end, queue and back end.
// Depends on cmf_pkg, cmf_front, cmf_queue and cmf_back.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tdata {msg_length, data_byte}, tuser msg_type
//   rsp      out        rsp_tvalid/tready    tdata out_byte, tlast chunk_end, tuser run_last
//   csr      in         csr_valid/ready      csr_index, csr_data
//
// One input transaction per cycle while the four-entry queue is not full; silent bytes
// take no queue slot but are held off too while the queue is full.
// Output: one byte per cycle while rsp is not stalled; a byte that opens a chunk follows its eight header bytes.
// Stalls on rsp back up through the queue to req_tready; csr_ready is always high.
// Synchronous active-high reset; no clearing pass.
module chunked_message_framer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cmf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cmf_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // data_byte[7:0], msg_length[23:8]
   input  logic [7:0]                       req_tuser,  // msg_type[7:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,  // out_byte[7:0]
   output logic                             rsp_tlast,  // chunk_end
   output logic                             rsp_tuser   // run_last[0]
);

   logic                   queue_full, queue_empty, queue_push, queue_pop;
   cmf_pkg::cmf_entry_type push_entry, head_entry;

   cmf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .data_byte   (req_tdata[7:0]),
      .msg_type    (req_tuser),
      .msg_length  (req_tdata[23:8]),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry)
   );

   cmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .head_entry (head_entry)
   );

   cmf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_entry  (head_entry),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_byte    (rsp_tdata),
      .chunk_end   (rsp_tlast),
      .run_last    (rsp_tuser)
   );

endmodule
